// ===== sv/b2r_pkg.sv =====
// ============================================================================
// b2r_pkg: shared types and constants for the BMP 24-bit to RGB565 block
// Header byte positions, config register indexes, header status struct and
// the RGB565 packing function.
// ============================================================================
`default_nettype none

package b2r_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned ROW_W      = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

    // header byte positions
    localparam logic [POS_W-1:0] POS_OFFSET_B0 = 32'd10;
    localparam logic [POS_W-1:0] POS_OFFSET_B1 = 32'd11;
    localparam logic [POS_W-1:0] POS_OFFSET_B2 = 32'd12;
    localparam logic [POS_W-1:0] POS_OFFSET_B3 = 32'd13;
    localparam logic [POS_W-1:0] POS_WIDTH_B0  = 32'd18;
    localparam logic [POS_W-1:0] POS_WIDTH_B1  = 32'd19;
    localparam logic [POS_W-1:0] POS_HEIGHT_B0 = 32'd22;
    localparam logic [POS_W-1:0] POS_HEIGHT_B1 = 32'd23;
    localparam logic [POS_W-1:0] POS_DEPTH     = 32'd28;
    localparam logic [POS_W-1:0] POS_DATA_MIN  = 32'd29;
    localparam logic [POS_W-1:0] POS_MAX       = '1;

    localparam logic [7:0] DEPTH_RGB24 = 8'd24;

    typedef struct packed {
        logic            pix_en;     // current byte lies in pixel data of a 24-bit file
        logic [15:0]     width;
        logic [15:0]     height;
        logic [ROW_W-1:0] pix_bytes; // width * 3
        logic [ROW_W-1:0] row_size;  // pix_bytes rounded up to 4
    } hdr_t;

    function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        rgb565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/b2r_if.sv =====
// ============================================================================
// b2r interfaces: valid/ready channels for file bytes, pixels and config
// Each channel has a source and a sink modport.
// ============================================================================
`default_nettype none

interface b2r_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface b2r_pix_if;
    logic        valid;
    logic        ready;
    logic [16:0] pixel_x;
    logic [16:0] pixel_y;
    logic [15:0] color565;

    modport source (output valid, output pixel_x, output pixel_y, output color565,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input color565,
                    output ready);
endinterface

interface b2r_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [b2r_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [b2r_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/bmp24_to_rgb565_pixels_top.sv =====
// ============================================================================
// bmp24_to_rgb565_pixels_top: BMP 24-bit byte stream to RGB565 pixels
// Parses the header, walks padded bottom-up rows and emits one placed pixel
// per complete B, G, R triple.
// ============================================================================
//  channel | dir | fields                          | notes
//  bytes   | in  | file_byte, end_of_file          | one file byte per word
//  pixels  | out | pixel_x, pixel_y, color565      | at most one per byte
//  cfg     | in  | reg_index, wdata                | origin_x, origin_y; always ready
//
//  One byte per cycle unless stalled; a pixel is registered in the cycle
//  after the byte that completes it. The output register holds a word until
//  taken and bytes keep flowing while it is empty or being taken in the same
//  cycle. Asynchronous active-low reset clears all state but the pixel word;
//  end_of_file clears the parse state after its byte, origins are kept.
// ============================================================================
`default_nettype none

module bmp24_to_rgb565_pixels_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    b2r_byte_if.sink   bytes,
    b2r_pix_if.source  pixels,
    b2r_cfg_if.sink    cfg
);

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;

    b2r_pkg::hdr_t hdr;
    logic          accept;

    logic [14:0]               origin_x_reg, origin_y_reg;
    logic [b2r_pkg::ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [15:0]               col_reg, col_next;
    logic [15:0]               file_row_reg, file_row_next;
    logic [1:0]                phase_reg, phase_next;
    logic [7:0]                blue_reg, blue_next;
    logic [7:0]                green_reg, green_next;
    logic                      out_valid_reg, out_valid_next;
    logic [16:0]               px_reg, py_reg;
    logic [15:0]               color_reg;

    logic                      active, in_row, emit, end_row;
    logic [b2r_pkg::ROW_W:0]   row_cnt_inc;
    logic [15:0]               y_off;

    assign accept      = bytes.valid && bytes.ready;
    assign bytes.ready = !out_valid_reg || pixels.ready;
    assign cfg.ready   = 1'b1;

    b2r_hdr u_hdr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .file_byte   (bytes.file_byte),
        .end_of_file (bytes.end_of_file),
        .hdr         (hdr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.reg_index == b2r_pkg::CFG_ORIGIN_X)
                origin_x_reg <= cfg.wdata;
            else if (cfg.reg_index == b2r_pkg::CFG_ORIGIN_Y)
                origin_y_reg <= cfg.wdata;
        end
    end

    assign active = hdr.pix_en && (hdr.row_size != '0) && (hdr.height != '0) &&
                    (file_row_reg < hdr.height);
    assign in_row      = row_cnt_reg < hdr.pix_bytes;
    assign emit        = active && in_row && (phase_reg == PH_RED);
    assign row_cnt_inc = {1'b0, row_cnt_reg} + 1'b1;
    assign end_row     = row_cnt_inc >= {1'b0, hdr.row_size};
    // rows are stored bottom-up
    assign y_off       = hdr.height - 16'd1 - file_row_reg;

    always_comb
    begin
        row_cnt_next  = row_cnt_reg;
        col_next      = col_reg;
        file_row_next = file_row_reg;
        phase_next    = phase_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        if (accept)
        begin
            if (active)
            begin
                if (in_row)
                begin
                    unique case (phase_reg)
                        PH_BLUE:
                        begin
                            blue_next  = bytes.file_byte;
                            phase_next = PH_GREEN;
                        end
                        PH_GREEN:
                        begin
                            green_next = bytes.file_byte;
                            phase_next = PH_RED;
                        end
                        default:
                        begin
                            phase_next = PH_BLUE;
                            col_next   = col_reg + 1'b1;
                        end
                    endcase
                end
                if (end_row)
                begin
                    row_cnt_next  = '0;
                    col_next      = '0;
                    phase_next    = PH_BLUE;
                    file_row_next = file_row_reg + 1'b1;
                end
                else
                    row_cnt_next = row_cnt_inc[b2r_pkg::ROW_W-1:0];
            end
            if (bytes.end_of_file)
            begin
                row_cnt_next  = '0;
                col_next      = '0;
                file_row_next = '0;
                phase_next    = PH_BLUE;
                blue_next     = '0;
                green_next    = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = emit;
        else if (pixels.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            col_reg       <= '0;
            file_row_reg  <= '0;
            phase_reg     <= PH_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_cnt_reg   <= row_cnt_next;
            col_reg       <= col_next;
            file_row_reg  <= file_row_next;
            phase_reg     <= phase_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            px_reg    <= {2'b00, origin_x_reg} + {1'b0, col_reg};
            py_reg    <= {2'b00, origin_y_reg} + {1'b0, y_off};
            color_reg <= b2r_pkg::rgb565(bytes.file_byte, green_reg, blue_reg);
        end
    end

    assign pixels.valid    = out_valid_reg;
    assign pixels.pixel_x  = px_reg;
    assign pixels.pixel_y  = py_reg;
    assign pixels.color565 = color_reg;

endmodule

`default_nettype wire

// ===== sv/b2r_hdr.sv =====
// ============================================================================
// b2r_hdr: BMP header capture
// Counts file bytes, captures offset, width, height and depth, and flags the
// bytes that belong to 24-bit pixel data.
// ============================================================================
`default_nettype none

module b2r_hdr (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  file_byte,
    input  wire logic        end_of_file,
    output b2r_pkg::hdr_t    hdr
);

    logic [b2r_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0]               offset_reg, offset_next;
    logic [15:0]               width_reg, width_next;
    logic [15:0]               height_reg, height_next;
    logic [7:0]                depth_reg, depth_next;
    logic [b2r_pkg::ROW_W-1:0] pix_bytes_reg, pix_bytes_next;
    logic [b2r_pkg::ROW_W-1:0] row_size_reg, row_size_next;

    always_comb
    begin
        pos_next    = pos_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        if (accept)
        begin
            unique case (pos_reg)
                b2r_pkg::POS_OFFSET_B0: offset_next[7:0]   = file_byte;
                b2r_pkg::POS_OFFSET_B1: offset_next[15:8]  = file_byte;
                b2r_pkg::POS_OFFSET_B2: offset_next[23:16] = file_byte;
                b2r_pkg::POS_OFFSET_B3: offset_next[31:24] = file_byte;
                b2r_pkg::POS_WIDTH_B0:  width_next[7:0]    = file_byte;
                b2r_pkg::POS_WIDTH_B1:  width_next[15:8]   = file_byte;
                b2r_pkg::POS_HEIGHT_B0: height_next[7:0]   = file_byte;
                b2r_pkg::POS_HEIGHT_B1: height_next[15:8]  = file_byte;
                b2r_pkg::POS_DEPTH:     depth_next         = file_byte;
                default: ;
            endcase
            if (pos_reg != b2r_pkg::POS_MAX)
                pos_next = pos_reg + 1'b1;
            if (end_of_file)
            begin
                pos_next    = '0;
                offset_next = '0;
                width_next  = '0;
                height_next = '0;
                depth_next  = '0;
            end
        end
    end

    // row geometry is registered from width via pix_bytes_reg, then row_size_reg; width settles well before pixel data
    assign pix_bytes_next = {1'b0, width_reg, 1'b0} + {2'b00, width_reg};
    assign row_size_next  = (pix_bytes_reg + 18'd3) & ~18'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            offset_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            depth_reg     <= '0;
            pix_bytes_reg <= '0;
            row_size_reg  <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            offset_reg    <= offset_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            depth_reg     <= depth_next;
            pix_bytes_reg <= pix_bytes_next;
            row_size_reg  <= row_size_next;
        end
    end

    assign hdr.pix_en = (pos_reg >= b2r_pkg::POS_DATA_MIN) &&
                        (offset_reg >= b2r_pkg::POS_DATA_MIN) &&
                        (pos_reg >= offset_reg) &&
                        (depth_reg == b2r_pkg::DEPTH_RGB24);
    assign hdr.width     = width_reg;
    assign hdr.height    = height_reg;
    assign hdr.pix_bytes = pix_bytes_reg;
    assign hdr.row_size  = row_size_reg;

endmodule

`default_nettype wire

// ===== sv/b2r_chk.sv =====
// ============================================================================
// b2r_chk: port-level checks for the BMP to RGB565 block
// Watches the byte and pixel channels of the top level; bound below.
// ============================================================================
`default_nettype none

module b2r_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [16:0] pixel_x,
    input wire logic [16:0] pixel_y,
    input wire logic [15:0] color565
);

    // a stalled pixel word must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) &&
                                    $stable(pixel_y) && $stable(color565))
        else $error("pixel word changed while stalled");

    // a full, stalled output register blocks the byte side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("byte taken while pixel register full");

    // an empty output register always takes a byte
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("byte side stalled with empty output");

    // a new pixel word only follows an accepted byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("pixel word without a byte");

endmodule

bind bmp24_to_rgb565_pixels_top b2r_chk u_b2r_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bytes.valid),
    .in_ready  (bytes.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .pixel_x   (pixels.pixel_x),
    .pixel_y   (pixels.pixel_y),
    .color565  (pixels.color565)
);

`default_nettype wire
